// ===== rtl/telemetry_command_frame_receiver_macros.svh =====
// Assertion macros for the telemetry command frame receiver.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef TELEMETRY_COMMAND_FRAME_RECEIVER_MACROS_SVH
`define TELEMETRY_COMMAND_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication
`define TCFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tcfr_pkg.sv =====
// Shared types, codes and helpers of the telemetry command frame receiver.
// No dependencies.
`default_nettype none

package tcfr_pkg;

  typedef enum logic [2:0] {
    EV_CAL_ACCEL = 3'd0,
    EV_CAL_GYRO  = 3'd1,
    EV_GAIN_RPT  = 3'd2,
    EV_CHANNEL   = 3'd3,
    EV_TMO_CLR   = 3'd4,
    EV_GAIN      = 3'd5,
    EV_ACK       = 3'd6
  } ev_kind_t;

  localparam logic [7:0] HDR_B0      = 8'hAA;
  localparam logic [7:0] HDR_B1      = 8'hAF;
  localparam logic [7:0] CMD_CAL     = 8'h01;
  localparam logic [7:0] CMD_REPORT  = 8'h02;
  localparam logic [7:0] CMD_CHAN    = 8'h03;
  localparam logic [7:0] CMD_GAIN_A  = 8'h10;
  localparam logic [7:0] CMD_GAIN_B  = 8'h11;
  localparam logic [7:0] CMD_ACK_LO  = 8'h12;
  localparam logic [7:0] CMD_ACK_HI  = 8'h15;
  localparam logic [7:0] SUB_ACCEL   = 8'h01;
  localparam logic [7:0] SUB_GYRO    = 8'h02;
  localparam logic [7:0] SUB_BOTH    = 8'h03;
  localparam logic [7:0] SUB_REPORT  = 8'h01;

  // ack frame: AA AA F0 03 BA 00 S C
  localparam logic [7:0] ACK_B0 = 8'hAA;
  localparam logic [7:0] ACK_B1 = 8'hAA;
  localparam logic [7:0] ACK_B2 = 8'hF0;
  localparam logic [7:0] ACK_B3 = 8'h03;
  localparam logic [7:0] ACK_B4 = 8'hBA;
  localparam logic [7:0] ACK_B5 = 8'h00;
  localparam logic [7:0] ACK_CHK_BASE =
    8'((ACK_B0 + ACK_B1 + ACK_B2 + ACK_B3 + ACK_B4 + ACK_B5) % 256);

  function automatic logic [7:0] ack_byte(input logic [2:0] idx, input logic [7:0] s);
    logic [7:0] b;
    case (idx)
      3'd0:    b = ACK_B0;
      3'd1:    b = ACK_B1;
      3'd2:    b = ACK_B2;
      3'd3:    b = ACK_B3;
      3'd4:    b = ACK_B4;
      3'd5:    b = ACK_B5;
      3'd6:    b = s;
      default: b = s + ACK_CHK_BASE;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/telemetry_command_frame_receiver.sv =====
// Telemetry command frame receiver: byte intake, frame checks, event sequencer.
// Depends on tcfr_pkg and telemetry_command_frame_receiver_macros.svh.
// Non-final byte: in_tready stays high. Good final byte: header, command lookup H0..DEC,
// then EV_A, EV_B, EV_C per event (held in EV_C on out_tready stalls), up to 17 events,
// paced by the one-byte-per-cycle store read. in_tready is low until the last event is
// in the output register. Sync active-low reset clears counters, FSM, valid bits.
`default_nettype none

module telemetry_command_frame_receiver #(
  parameter int MAX_FRAME_BYTES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tlast,   // frame_end
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [23:0] out_tdata,  // [3:0] slot, [19:4] value, [23:20] zero
  output      logic [2:0]  out_tuser,  // [2:0] event_kind
  output      logic        out_tlast   // last_result
);

  import tcfr_pkg::*;

  `include "telemetry_command_frame_receiver_macros.svh"

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int IDX_W = $clog2(MAX_FRAME_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE,   // taking bytes
    ST_H0,     // read store[0]
    ST_H1,     // check header byte 0, read store[1]
    ST_H2,     // check header byte 1, read command
    ST_H3,     // latch command, read sub-command
    ST_DEC,    // pick the event burst
    ST_EV_A,   // read first byte of the event
    ST_EV_B,   // latch it, read next byte
    ST_EV_C    // build event, load output register
  } state_t;

  typedef enum logic [2:0] {
    M_CAL, M_REP, M_CHAN, M_G10, M_G11, M_ACK
  } mode_t;

  // control
  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [7:0]                sum_r, sum_nxt;
  logic                      ovr_r, ovr_nxt;
  logic [MAX_FRAME_BYTES-1:0] vld_r, vld_nxt;
  mode_t                     mode_r, mode_nxt;
  logic [4:0]                k_r, k_nxt;
  logic [4:0]                kend_r, kend_nxt;
  logic                      out_valid_r, out_valid_nxt;
  // payload
  logic [7:0]                s_r, s_nxt;
  logic [7:0]                cmd_r, cmd_nxt;
  logic [7:0]                hi_r, hi_nxt;
  logic [2:0]                out_kind_r, out_kind_nxt;
  logic [3:0]                out_slot_r, out_slot_nxt;
  logic [15:0]               out_value_r, out_value_nxt;
  logic                      out_last_r, out_last_nxt;

  // frame store
  logic [7:0]                mem [MAX_FRAME_BYTES];
  logic [7:0]                rd_data_r;
  logic                      rd_vld_r;
  logic                      rd_en, wr_en;
  logic [IDX_W-1:0]          rd_addr, wr_idx;
  logic [7:0]                rd_byte;

  logic                      in_acc, has_room, out_free, ld;

  // current event, decoded from burst mode and index
  logic [2:0]                ev_kind;
  logic [3:0]                ev_slot;
  logic [4:0]                ev_addr;
  logic [2:0]                ev_ack_idx;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign has_room  = (cnt_r < CNT_W'(MAX_FRAME_BYTES));
  assign wr_idx    = cnt_r[IDX_W-1:0];
  assign wr_en     = in_acc && has_room && (!in_tlast || !ovr_r);
  assign rd_byte   = rd_vld_r ? rd_data_r : 8'h00;   // never-written entry reads as zero
  assign out_free  = !out_valid_r || out_tready;
  assign ld        = (state_r == ST_EV_C) && out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, out_value_r, out_slot_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    ev_kind    = EV_ACK;
    ev_slot    = 4'd0;
    ev_addr    = 5'd0;
    ev_ack_idx = 3'd0;
    case (mode_r)
      M_CAL: begin
        ev_kind = k_r[0] ? EV_CAL_GYRO : EV_CAL_ACCEL;
      end
      M_REP: begin
        ev_kind = EV_GAIN_RPT;
      end
      M_CHAN: begin
        if (k_r < 5'd8) begin
          ev_kind = EV_CHANNEL;
          ev_slot = k_r[3:0];
          ev_addr = 5'(k_r << 1) + 5'd4;
        end else begin
          ev_kind = EV_TMO_CLR;
        end
      end
      M_G10: begin
        if (k_r < 5'd9) begin
          ev_kind = EV_GAIN;
          ev_slot = k_r[3:0];
          ev_addr = 5'(k_r << 1) + 5'd5;
        end else begin
          ev_ack_idx = 3'(k_r - 5'd9);
        end
      end
      M_G11: begin
        // altitude gains from pairs at 4..9, level gains from 16..21
        if (k_r < 5'd3) begin
          ev_kind = EV_GAIN;
          ev_slot = k_r[3:0] + 4'd9;
          ev_addr = 5'(k_r << 1) + 5'd5;
        end else if (k_r < 5'd6) begin
          ev_kind = EV_GAIN;
          ev_slot = k_r[3:0] + 4'd9;
          ev_addr = 5'(k_r << 1) + 5'd11;
        end else begin
          ev_ack_idx = 3'(k_r - 5'd6);
        end
      end
      M_ACK: begin
        ev_ack_idx = k_r[2:0];
      end
      default: begin
        ev_kind = EV_ACK;
      end
    endcase
  end

  // store read port control
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    case (state_r)
      ST_H0:   rd_addr = IDX_W'(0);
      ST_H1:   rd_addr = IDX_W'(1);
      ST_H2:   rd_addr = IDX_W'(2);
      ST_H3:   rd_addr = IDX_W'(4);
      ST_EV_A: rd_addr = IDX_W'(ev_addr);
      ST_EV_B: rd_addr = IDX_W'(ev_addr + 5'd1);
      default: rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    ovr_nxt       = ovr_r;
    vld_nxt       = vld_r;
    mode_nxt      = mode_r;
    k_nxt         = k_r;
    kend_nxt      = kend_r;
    s_nxt         = s_r;
    cmd_nxt       = cmd_r;
    hi_nxt        = hi_r;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (wr_en) begin
      vld_nxt[wr_idx] = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_tlast) begin
            if (has_room) begin
              cnt_nxt = cnt_r + CNT_W'(1);
              sum_nxt = sum_r + in_tdata;
            end else begin
              ovr_nxt = 1'b1;
            end
          end else begin
            // checksum byte: counters clear whatever the outcome
            cnt_nxt = '0;
            sum_nxt = '0;
            ovr_nxt = 1'b0;
            s_nxt   = sum_r;
            if (!ovr_r && has_room && (sum_r == in_tdata)) begin
              state_nxt = ST_H0;
            end
          end
        end
      end
      ST_H0: state_nxt = ST_H1;
      ST_H1: state_nxt = (rd_byte == HDR_B0) ? ST_H2 : ST_IDLE;
      ST_H2: state_nxt = (rd_byte == HDR_B1) ? ST_H3 : ST_IDLE;
      ST_H3: begin
        cmd_nxt   = rd_byte;
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        // rd_byte holds the sub-command here
        state_nxt = ST_EV_A;
        k_nxt     = 5'd0;
        case (cmd_r)
          CMD_CAL: begin
            mode_nxt = M_CAL;
            case (rd_byte)
              SUB_ACCEL: kend_nxt = 5'd0;
              SUB_GYRO: begin
                k_nxt    = 5'd1;
                kend_nxt = 5'd1;
              end
              SUB_BOTH:  kend_nxt = 5'd1;
              default:   state_nxt = ST_IDLE;
            endcase
          end
          CMD_REPORT: begin
            mode_nxt = M_REP;
            kend_nxt = 5'd0;
            if (rd_byte != SUB_REPORT) begin
              state_nxt = ST_IDLE;
            end
          end
          CMD_CHAN: begin
            mode_nxt = M_CHAN;
            kend_nxt = 5'd8;
          end
          CMD_GAIN_A: begin
            mode_nxt = M_G10;
            kend_nxt = 5'd16;
          end
          CMD_GAIN_B: begin
            mode_nxt = M_G11;
            kend_nxt = 5'd13;
          end
          default: begin
            mode_nxt = M_ACK;
            kend_nxt = 5'd7;
            if (!(cmd_r inside {[CMD_ACK_LO:CMD_ACK_HI]})) begin
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end
      ST_EV_A: state_nxt = ST_EV_B;
      ST_EV_B: begin
        hi_nxt    = rd_byte;
        state_nxt = ST_EV_C;
      end
      ST_EV_C: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = ev_kind;
          out_last_nxt  = (k_r == kend_r);
          out_slot_nxt  = 4'd0;
          out_value_nxt = 16'd0;
          case (ev_kind)
            EV_CHANNEL: begin
              out_slot_nxt  = ev_slot;
              out_value_nxt = {hi_r, rd_byte};
            end
            EV_GAIN: begin
              out_slot_nxt  = ev_slot;
              out_value_nxt = {8'h00, hi_r};
            end
            EV_ACK: begin
              out_slot_nxt  = {1'b0, ev_ack_idx};
              out_value_nxt = {8'h00, ack_byte(ev_ack_idx, s_r)};
            end
            default: begin
              out_slot_nxt = 4'd0;
            end
          endcase
          if (k_r == kend_r) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 5'd1;
            state_nxt = ST_EV_A;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    s_r         <= s_nxt;
    cmd_r       <= cmd_nxt;
    hi_r        <= hi_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      ovr_r       <= 1'b0;
      vld_r       <= '0;
      mode_r      <= M_ACK;
      k_r         <= '0;
      kend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      ovr_r       <= ovr_nxt;
      vld_r       <= vld_nxt;
      mode_r      <= mode_nxt;
      k_r         <= k_nxt;
      kend_r      <= kend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= in_tdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  `TCFR_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_FRAME_BYTES),
                   "byte count past store size")
  `TCFR_ASSERT_NXT(a_frame_clear, in_acc && in_tlast,
                   (cnt_r == '0) && (sum_r == '0) && !ovr_r,
                   "frame state not cleared at checksum byte")
  `TCFR_ASSERT_IMP(a_load_src, $rose(out_valid_r), $past(state_r == ST_EV_C),
                   "output loaded outside event stage")
  `TCFR_ASSERT_NXT(a_last_idle, ld && (k_r == kend_r), state_r == ST_IDLE,
                   "sequencer busy after last event")

endmodule

`default_nettype wire

// ===== tb/telemetry_command_frame_receiver_tb.sv =====
// Regression bench for telemetry_command_frame_receiver: streams radio payload frames in,
// predicts the event burst of every frame and checks each result transaction field by field.
// Depends on tcfr_pkg and the receiver RTL.
`timescale 1ns / 100ps

module telemetry_command_frame_receiver_tb;
  import tcfr_pkg::*;

  localparam int STORE_BYTES  = 32;     // frame store depth of the DUT
  localparam int TARGET_ITEMS = 450;    // minimum number of byte transactions to send
  localparam int DRAIN_LIMIT  = 20000;  // cycles allowed for the last bursts to drain
  localparam int SETTLE_CYC   = 64;     // longer than the header lookup plus a full 17-event burst
  localparam int HOLD_START   = 800;    // long receiver hold-off window
  localparam int HOLD_CYCLES  = 500;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } rx_item_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic [3:0]  slot;
    logic [15:0] value;
    logic        last_ev;
  } frame_event_t;

  // shapes of frame the random part builds
  typedef enum int {
    FR_CAL, FR_REPORT, FR_CHAN, FR_GAIN_A, FR_GAIN_B, FR_ACK, FR_OTHER_CMD,
    FR_BAD_SUM, FR_BAD_HDR, FR_OVERRUN, FR_FULL, FR_NOISE
  } frame_kind_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [7:0] rx_byte
  logic        in_tlast = 1'b0;   // frame_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [3:0] slot, [19:4] value, [23:20] zero
  logic [2:0]  out_tuser;         // [2:0] event_kind
  logic        out_tlast;         // last_result

  telemetry_command_frame_receiver #(
    .MAX_FRAME_BYTES(STORE_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #4 clk = ~clk;

  // byte transactions waiting to be offered, and events still owed by the DUT
  rx_item_t     tx_items[$];
  frame_event_t predicted_events[$];

  // predictor's own copy of the receiver state
  logic [7:0] rx_store [STORE_BYTES];
  int         rx_count = 0;
  logic [7:0] rx_sum = '0;
  logic       rx_overrun = 1'b0;

  int err_cnt = 0;
  int items_sent = 0;
  int total_items = 0;
  int events_checked = 0;
  int frames_taken = 0;
  int frames_dropped = 0;
  int longest_burst = 0;

  // idle lengths: mostly none or short, now and then a long one
  function automatic int idle_len(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_event(input ev_kind_t k, input logic [3:0] slot,
                                    input logic [15:0] v);
    frame_event_t ev;
    ev.kind    = k;
    ev.slot    = slot;
    ev.value   = v;
    ev.last_ev = 1'b0;
    predicted_events.push_back(ev);
  endfunction

  // Absorb one accepted byte; on the frame end, queue the burst the frame triggers.
  task automatic predict_byte(input logic [7:0] b, input logic fin);
    logic        fits;
    logic        want_ack;
    logic [7:0]  s, cmd, sub, chk;
    logic [7:0]  ack [8];
    int          first;
    frame_event_t ev;
    if (!fin) begin
      if (rx_count < STORE_BYTES) begin
        rx_store[rx_count] = b;
        rx_count++;
        rx_sum += b;
      end else begin
        rx_overrun = 1'b1;
      end
      return;
    end
    // checksum byte lands in the store too, as long as there is room
    fits = !rx_overrun && rx_count < STORE_BYTES;
    if (fits) rx_store[rx_count] = b;
    s = rx_sum;
    rx_count = 0;
    rx_sum = '0;
    rx_overrun = 1'b0;
    if (!fits || s != b || rx_store[0] != HDR_B0 || rx_store[1] != HDR_B1) begin
      frames_dropped++;
      return;
    end
    frames_taken++;
    first = predicted_events.size();
    want_ack = 1'b0;
    cmd = rx_store[2];
    sub = rx_store[4];
    if (cmd == CMD_CAL) begin
      if (sub == SUB_ACCEL || sub == SUB_BOTH) add_event(EV_CAL_ACCEL, '0, '0);
      if (sub == SUB_GYRO || sub == SUB_BOTH) add_event(EV_CAL_GYRO, '0, '0);
    end else if (cmd == CMD_REPORT) begin
      if (sub == SUB_REPORT) add_event(EV_GAIN_RPT, '0, '0);
    end else if (cmd == CMD_CHAN) begin
      for (int i = 0; i < 8; i++)
        add_event(EV_CHANNEL, 4'(i), {rx_store[4 + 2 * i], rx_store[5 + 2 * i]});
      add_event(EV_TMO_CLR, '0, '0);
    end else if (cmd == CMD_GAIN_A) begin
      // roll, pitch, yaw: gain byte is the low byte of each pair
      for (int i = 0; i < 9; i++)
        add_event(EV_GAIN, 4'(i), {8'h00, rx_store[5 + 2 * i]});
      want_ack = 1'b1;
    end else if (cmd == CMD_GAIN_B) begin
      // altitude from pairs 4..9, level from pairs 16..21
      for (int i = 0; i < 3; i++)
        add_event(EV_GAIN, 4'(9 + i), {8'h00, rx_store[5 + 2 * i]});
      for (int i = 0; i < 3; i++)
        add_event(EV_GAIN, 4'(12 + i), {8'h00, rx_store[17 + 2 * i]});
      want_ack = 1'b1;
    end else if (cmd >= CMD_ACK_LO && cmd <= CMD_ACK_HI) begin
      want_ack = 1'b1;
    end
    if (want_ack) begin
      ack[0] = ACK_B0;
      ack[1] = ACK_B1;
      ack[2] = ACK_B2;
      ack[3] = ACK_B3;
      ack[4] = ACK_B4;
      ack[5] = ACK_B5;
      ack[6] = s;
      chk = '0;
      for (int i = 0; i < 7; i++) chk += ack[i];
      ack[7] = chk;
      for (int i = 0; i < 8; i++) add_event(EV_ACK, 4'(i), {8'h00, ack[i]});
    end
    // flag the closing event of the burst
    if (predicted_events.size() > first) begin
      ev = predicted_events.pop_back();
      ev.last_ev = 1'b1;
      predicted_events.push_back(ev);
      if (predicted_events.size() - first > longest_burst)
        longest_burst = predicted_events.size() - first;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued bytes, with random gaps and stretches without any.
  // ---------------------------------------------------------------------------
  rx_item_t next_item;
  int       tx_gap = 0;
  bit       tx_steady = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_byte(in_tdata, in_tlast);
        items_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (tx_items.size() > 0) begin
          next_item = tx_items.pop_front();
          in_tdata  <= next_item.data;
          in_tlast  <= next_item.fin;
          in_tvalid <= 1'b1;
          tx_gap = idle_len(tx_steady);
          if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-off: the sender keeps offering, so a frame end parks the
  // burst in the DUT and in_tready has to stay low until it drains.
  // ---------------------------------------------------------------------------
  int   cyc_cnt = 0;
  logic hold_off = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      cyc_cnt  <= 0;
      hold_off <= 1'b0;
    end else begin
      cyc_cnt  <= cyc_cnt + 1;
      hold_off <= cyc_cnt >= HOLD_START && cyc_cnt < HOLD_START + HOLD_CYCLES;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, every result transaction checked in order.
  // ---------------------------------------------------------------------------
  frame_event_t want;
  int           rx_stall = 0;
  bit           rx_steady = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (predicted_events.size() == 0) begin
          $error("unexpected event: kind %0d slot %0d value %0h last %0b",
                 out_tuser, out_tdata[3:0], out_tdata[19:4], out_tlast);
          err_cnt++;
        end else begin
          want = predicted_events.pop_front();
          if (out_tuser !== want.kind) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, out_tuser);
            err_cnt++;
          end
          if (out_tdata[3:0] !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, out_tdata[3:0]);
            err_cnt++;
          end
          if (out_tdata[19:4] !== want.value) begin
            $error("value: expected %04h, actual %04h", want.value, out_tdata[19:4]);
            err_cnt++;
          end
          if (out_tlast !== want.last_ev) begin
            $error("last_result: expected %0b, actual %0b", want.last_ev, out_tlast);
            err_cnt++;
          end
          events_checked++;
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !hold_off;
        if (!rx_steady && $urandom_range(0, 3) == 0) rx_stall = idle_len(1'b0);
        if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Frame body: header, command, a spare byte, sub-command, then random payload.
  task automatic make_frame(output byte_q_t f, input logic [7:0] cmd,
                            input logic [7:0] sub, input int len);
    f = {};
    for (int i = 0; i < len; i++) begin
      case (i)
        0:       f.push_back(HDR_B0);
        1:       f.push_back(HDR_B1);
        2:       f.push_back(cmd);
        4:       f.push_back(sub);
        default: f.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Queue the body, then the checksum byte (spoiled when asked).
  task automatic send_frame(input byte_q_t f, input bit corrupt);
    logic [7:0] sum;
    rx_item_t   it;
    sum = '0;
    foreach (f[i]) begin
      it.data = f[i];
      it.fin  = 1'b0;
      tx_items.push_back(it);
      sum += f[i];
    end
    if (corrupt) sum += 8'($urandom_range(1, 255));
    it.data = sum;
    it.fin  = 1'b1;
    tx_items.push_back(it);
  endtask

  function automatic logic [7:0] pick_sub();
    int r;
    r = $urandom_range(0, 5);
    if (r < 4) return 8'(r);   // none, accel/report, gyro, both
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic frame_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return FR_CAL;
    if (r < 16) return FR_REPORT;
    if (r < 28) return FR_CHAN;
    if (r < 40) return FR_GAIN_A;
    if (r < 52) return FR_GAIN_B;
    if (r < 62) return FR_ACK;
    if (r < 67) return FR_OTHER_CMD;
    if (r < 75) return FR_BAD_SUM;
    if (r < 82) return FR_BAD_HDR;
    if (r < 88) return FR_OVERRUN;
    if (r < 93) return FR_FULL;
    return FR_NOISE;
  endfunction

  // burst commands mostly get a full frame, sometimes a random length that, if short, reads stale bytes
  function automatic int burst_len();
    return ($urandom_range(0, 3) != 0) ? 22 : $urandom_range(3, 31);
  endfunction

  initial begin
    byte_q_t     f;
    frame_kind_e kind;
    rx_item_t    it;
    int          drain;

    foreach (rx_store[i]) rx_store[i] = '0;

    // directed: short frames, stale store reads, empty frame, broken header
    make_frame(f, CMD_REPORT, SUB_REPORT, 5);
    send_frame(f, 1'b0);
    make_frame(f, CMD_CAL, SUB_BOTH, 5);
    send_frame(f, 1'b0);
    make_frame(f, CMD_ACK_LO, '0, 3);
    send_frame(f, 1'b0);
    make_frame(f, CMD_CHAN, '0, 3);        // channels from whatever the store holds
    send_frame(f, 1'b0);
    f = {};
    send_frame(f, 1'b0);                   // lone checksum byte 00
    f = {HDR_B0, 8'hFF, CMD_ACK_LO};
    send_frame(f, 1'b0);

    // random: every frame shape once, then weighted picks
    for (int n = 0; tx_items.size() < TARGET_ITEMS; n++) begin
      kind = (n <= int'(FR_NOISE)) ? frame_kind_e'(n) : pick_kind();
      case (kind)
        FR_CAL: begin
          make_frame(f, CMD_CAL, pick_sub(), $urandom_range(3, 10));
          send_frame(f, 1'b0);
        end
        FR_REPORT: begin
          make_frame(f, CMD_REPORT, pick_sub(), $urandom_range(3, 10));
          send_frame(f, 1'b0);
        end
        FR_CHAN: begin
          make_frame(f, CMD_CHAN, pick_sub(), burst_len());
          send_frame(f, 1'b0);
        end
        FR_GAIN_A: begin
          make_frame(f, CMD_GAIN_A, pick_sub(), burst_len());
          send_frame(f, 1'b0);
        end
        FR_GAIN_B: begin
          make_frame(f, CMD_GAIN_B, pick_sub(), burst_len());
          send_frame(f, 1'b0);
        end
        FR_ACK: begin
          make_frame(f, 8'(CMD_ACK_LO + $urandom_range(0, 3)), pick_sub(),
                     $urandom_range(3, 12));
          send_frame(f, 1'b0);
        end
        FR_OTHER_CMD: begin
          make_frame(f, 8'($urandom_range(0, 255)), pick_sub(), $urandom_range(3, 31));
          send_frame(f, 1'b0);
        end
        FR_BAD_SUM: begin
          make_frame(f, CMD_CHAN, pick_sub(), $urandom_range(3, 22));
          send_frame(f, 1'b1);
        end
        FR_BAD_HDR: begin
          make_frame(f, CMD_ACK_LO, '0, $urandom_range(3, 8));
          it.data = 8'($urandom_range(1, 255));
          if ($urandom_range(0, 1) == 0) f[0] = f[0] ^ it.data;
          else f[1] = f[1] ^ it.data;
          send_frame(f, 1'b0);
        end
        FR_OVERRUN: begin
          // more bytes than the store holds: dropped at the checksum
          make_frame(f, CMD_ACK_HI, '0, $urandom_range(STORE_BYTES + 1, STORE_BYTES + 8));
          send_frame(f, 1'b0);
        end
        FR_FULL: begin
          // store exactly full when the checksum arrives: dropped too
          make_frame(f, CMD_ACK_LO, '0, STORE_BYTES);
          send_frame(f, 1'b0);
        end
        default: begin
          // noise with stray frame ends, closed by one so the next frame starts clean
          repeat ($urandom_range(1, 10)) begin
            it.data = 8'($urandom_range(0, 255));
            it.fin  = ($urandom_range(0, 7) == 0);
            tx_items.push_back(it);
          end
          it.data = 8'($urandom_range(0, 255));
          it.fin  = 1'b1;
          tx_items.push_back(it);
        end
      endcase
    end
    total_items = tx_items.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (items_sent < total_items) @(posedge clk);
    drain = 0;
    while (predicted_events.size() > 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
    if (predicted_events.size() > 0) begin
      $error("%0d predicted events never arrived", predicted_events.size());
      err_cnt++;
    end

    $display("%0d byte transactions, %0d frames taken, %0d frames dropped",
             items_sent, frames_taken, frames_dropped);
    $display("%0d events checked, longest burst %0d events", events_checked, longest_burst);
    if (err_cnt == 0) begin
      $display("telemetry_command_frame_receiver regression: pass");
    end else begin
      $display("telemetry_command_frame_receiver regression: fail");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #3000000;
    $display("telemetry_command_frame_receiver regression: fail");
    $finish;
  end

endmodule
